>>> rtl/udiv_pkg.sv
// Shared types and constants for the unsigned divider.
package udiv_pkg;

  localparam int FIELD_BITS = 32;

  typedef logic [FIELD_BITS-1:0] field_t;

endpackage

>>> rtl/udiv_if.sv
// Valid/ready channel interfaces for operand words and result words.
interface udiv_in_if;
  import udiv_pkg::*;

  logic   valid;
  logic   ready;
  field_t dividend;
  field_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udiv_out_if;
  import udiv_pkg::*;

  logic   valid;
  logic   ready;
  field_t quotient;
  field_t remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

>>> rtl/unsigned_divider_quotient_remainder.sv
// Unsigned divider top level: quotient and remainder by pipelined restoring division.
// A new dividend/divisor word can be taken on every clock while the output keeps up;
// each word passes through WORD_BITS register stages, one per quotient bit from the
// most significant end, and the last stage register holds the result.
// Each stage holds one compare-and-subtract of WORD_BITS bits, and that sets the clock.
// Operands are cut to (or zero-extended to) WORD_BITS bits before division and results
// are presented on 32-bit fields. A zero divisor is not trapped: the quotient is zero and
// the remainder equals the dividend. Every stage has its own valid bit and the ready
// chain lets bubbles close up, so a stalled output holds its word while earlier stages
// keep filling; nothing is kept between words and reset only clears the valid bits.
module unsigned_divider_quotient_remainder #(
  parameter int WORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  udiv_in_if.sink         in_chan,
  udiv_out_if.source      out_chan
);
  import udiv_pkg::*;

  logic                 valid_s [0:WORD_BITS];
  logic                 ready_s [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] quo_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] div_s   [0:WORD_BITS];

  // Feed the head of the pipe; cut or widen operands to the working word.
  assign valid_s[0]    = in_chan.valid;
  assign in_chan.ready = ready_s[0];
  assign rem_s[0]      = WORD_BITS'(in_chan.dividend);
  assign div_s[0]      = WORD_BITS'(in_chan.divisor);
  assign quo_s[0]      = '0;

  // Stage k settles quotient bit WORD_BITS-1-k.
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
    udiv_stage #(
      .WORD_BITS (WORD_BITS),
      .SHIFT     (WORD_BITS - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_s[k]),
      .up_ready (ready_s[k]),
      .up_rem   (rem_s[k]),
      .up_quo   (quo_s[k]),
      .up_div   (div_s[k]),
      .dn_valid (valid_s[k+1]),
      .dn_ready (ready_s[k+1]),
      .dn_rem   (rem_s[k+1]),
      .dn_quo   (quo_s[k+1]),
      .dn_div   (div_s[k+1])
    );
  end

  // The last stage register doubles as the output register.
  assign out_chan.valid      = valid_s[WORD_BITS];
  assign ready_s[WORD_BITS]  = out_chan.ready;
  assign out_chan.quotient   = FIELD_BITS'(quo_s[WORD_BITS]);
  assign out_chan.remainder  = FIELD_BITS'(rem_s[WORD_BITS]);

  // A finished word always has its remainder below a non-zero divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    valid_s[WORD_BITS] && (div_s[WORD_BITS] != '0) |->
      rem_s[WORD_BITS] < div_s[WORD_BITS])
    else $error("remainder not below divisor");

  // A zero divisor never sets a quotient bit.
  a_zero_div_quo: assert property (@(posedge clk) disable iff (!rst_n)
    valid_s[WORD_BITS] && (div_s[WORD_BITS] == '0) |-> quo_s[WORD_BITS] == '0)
    else $error("quotient non-zero for zero divisor");

  // An accepted operand word lands in the first stage.
  a_first_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> valid_s[1])
    else $error("accepted word lost at first stage");

endmodule

>>> rtl/udiv_stage.sv
// One restoring-division stage: settles a single quotient bit and registers the word.
module udiv_stage #(
  parameter int WORD_BITS = 32,
  parameter int SHIFT     = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [WORD_BITS-1:0] up_rem,
  input  logic [WORD_BITS-1:0] up_quo,
  input  logic [WORD_BITS-1:0] up_div,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [WORD_BITS-1:0] dn_rem,
  output logic [WORD_BITS-1:0] dn_quo,
  output logic [WORD_BITS-1:0] dn_div
);

  logic                 valid_r, valid_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] div_r;
  logic                 take_bit;

  // Shifted divisor fits the word exactly when the partial remainder's top bits reach it.
  assign take_bit = (up_div != '0) && ((up_rem >> SHIFT) >= up_div);

  always_comb begin
    rem_nxt = take_bit ? (up_rem - (up_div << SHIFT)) : up_rem;
    quo_nxt = {up_quo[WORD_BITS-2:0], take_bit};
  end

  // Advance when empty or when the next stage takes the held word.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      div_r <= up_div;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_quo   = quo_r;
  assign dn_div   = div_r;

endmodule
